// ----- hdl/ile_pkg.sv -----
// Shared types and codes for the indexed list engine.
// Used by the cell, the cell chain and the top level; depends on nothing.
package ile_pkg;

  // Request operation codes.
  localparam logic [3:0] FN_GET    = 4'd0;
  localparam logic [3:0] FN_SIZE   = 4'd1;
  localparam logic [3:0] FN_FIND   = 4'd2;
  localparam logic [3:0] FN_SET    = 4'd3;
  localparam logic [3:0] FN_INSERT = 4'd4;
  localparam logic [3:0] FN_REMOVE = 4'd5;
  localparam logic [3:0] FN_APPEND = 4'd6;
  localparam logic [3:0] FN_DROP   = 4'd7;
  localparam logic [3:0] FN_CLEAR  = 4'd8;
  localparam logic [3:0] FN_BURST  = 4'd9;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Most results a single request may return.
  localparam int MAX_RES = 64;

  // Operations a cell applies to its entry.
  localparam logic [1:0] CELL_NOP = 2'd0;
  localparam logic [1:0] CELL_SET = 2'd1;
  localparam logic [1:0] CELL_INS = 2'd2;
  localparam logic [1:0] CELL_REM = 2'd3;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } cell_cmd_t;

endpackage

// ----- hdl/ile_cell.sv -----
// One cell of the list chain: holds a single entry and its match flag.
// Depends on ile_pkg for the cell command type and codes.
module ile_cell
  import ile_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int LEN_W = 7
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] wr_ptr,
  input  logic [31:0]      left,
  input  logic [31:0]      right,
  input  logic [31:0]      key,
  input  logic [LEN_W-1:0] len,
  output logic [31:0]      entry,
  output logic             match
);

  logic [31:0] entry_r;
  logic        match_r;
  logic        at_ptr;
  logic        past_ptr;

  assign at_ptr   = (wr_ptr == IDX_W'(IDX));
  assign past_ptr = (IDX_W'(IDX) > wr_ptr);

  // Entry update: overwrite, take the left neighbor on insert, the right one on remove.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_SET: begin
        if (at_ptr) begin
          entry_r <= cmd.value;
        end
      end
      CELL_INS: begin
        if (at_ptr) begin
          entry_r <= cmd.value;
        end else if (past_ptr) begin
          entry_r <= left;
        end
      end
      CELL_REM: begin
        if (at_ptr || past_ptr) begin
          entry_r <= right;
        end
      end
      CELL_NOP: begin
      end
    endcase
  end

  // A live entry equal to the search key raises its match flag.
  always_ff @(posedge clk) begin
    match_r <= (entry_r == key) && (LEN_W'(IDX) < len);
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ----- hdl/ile_chain.sv -----
// Row of list cells with the read selector and the first-match encoder.
// Depends on ile_pkg and ile_cell.
module ile_chain
  import ile_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int LEN_W = 7
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] wr_ptr,
  input  logic [31:0]      key,
  input  logic [LEN_W-1:0] len,
  input  logic [IDX_W-1:0] rd_ptr,
  output logic [31:0]      rd_data,
  output logic             hit,
  output logic [IDX_W-1:0] hit_pos
);

  logic [31:0]      entry [DEPTH];
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] first;

  // Each cell sees its neighbors; the ends see zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [31:0] left_w;
    logic [31:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[g+1];
    end
    ile_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .wr_ptr (wr_ptr),
      .left   (left_w),
      .right  (right_w),
      .key    (key),
      .len    (len),
      .entry  (entry[g]),
      .match  (match[g])
    );
  end

  // Read selector: AND-OR over the cells.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | (entry[i] & {32{rd_ptr == IDX_W'(i)}});
    end
  end

  // Lowest matching cell, isolated as a one-hot vector and then encoded.
  assign first = match & (~match + DEPTH'(1));
  assign hit   = |match;

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_pos = hit_pos | (IDX_W'(i) & {IDX_W{first[i]}});
    end
  end

endmodule

// ----- hdl/indexed_list_engine_top.sv -----
// Indexed list engine: an ordered list of 32-bit handles held in a row of cells,
// one entry per cell, with get, size, find, set, insert, remove, append, drop,
// clear and burst read. A request is taken in the idle state and executed in the
// execute state, which waits while the output is stalled; find first passes an
// evaluate state where every cell compares its entry with the key. Insert and
// remove shift all cells at once in the execute cycle. A burst read returns one
// entry per cycle while the output is not stalled. Each result sits in an output
// register, so the next request is taken while one waits. Uses ile_pkg, ile_chain.
module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_func,
  input  logic [7:0]  in_index,
  input  logic [31:0] in_value_in,
  input  logic [6:0]  in_count_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [6:0]  out_position,
  output logic        out_found,
  output logic [6:0]  out_length_now,
  output logic        out_item_valid,
  output logic        out_last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_BURST = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [6:0]       burst_n_r, burst_n_nxt;
  logic [6:0]       left_r, left_nxt;

  logic [3:0]       req_func_r;
  logic [7:0]       req_index_r;
  logic [31:0]      req_value_r;
  logic [6:0]       req_limit_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_value_r;
  logic [6:0]       out_position_r;
  logic             out_found_r;
  logic [6:0]       out_length_r;
  logic             out_item_valid_r;
  logic             out_last_r;

  logic             in_take;
  logic             out_free;
  logic             load_out;
  logic [1:0]       res_status;
  logic [31:0]      res_value;
  logic [6:0]       res_position;
  logic             res_found;
  logic             res_item_valid;
  logic             res_last;

  cell_cmd_t        cmd;
  logic [IDX_W-1:0] wr_ptr;
  logic [31:0]      rd_data;
  logic             hit;
  logic [IDX_W-1:0] hit_pos;

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] ins_pos;
  logic [CMP_W-1:0] remain;
  logic [CMP_W-1:0] burst_cnt;
  logic [IDX_W-1:0] in_ptr;
  logic             idx_oob;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_ptr   = IDX_W'(CMP_W'(in_index));

  // Request decode helpers.
  assign idx_ext = CMP_W'(req_index_r);
  assign len_ext = CMP_W'(len_r);
  assign idx_oob = (idx_ext >= len_ext);
  assign ins_pos = (req_func_r == FN_APPEND) ? len_ext : idx_ext;
  assign remain  = len_ext - idx_ext;

  // Burst length: the least of the limit, the entries left and the result cap.
  always_comb begin
    burst_cnt = remain;
    if (CMP_W'(req_limit_r) < burst_cnt) begin
      burst_cnt = CMP_W'(req_limit_r);
    end
    if (CMP_W'(MAX_RES) < burst_cnt) begin
      burst_cnt = CMP_W'(MAX_RES);
    end
  end

  // Control and result selection.
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    rd_ptr_nxt     = rd_ptr_r;
    burst_n_nxt    = burst_n_r;
    left_nxt       = left_r;
    cmd.op         = CELL_NOP;
    cmd.value      = req_value_r;
    wr_ptr         = idx_ext[IDX_W-1:0];
    load_out       = 1'b0;
    res_status     = ST_OK;
    res_value      = '0;
    res_position   = '0;
    res_found      = 1'b0;
    res_item_valid = 1'b0;
    res_last       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rd_ptr_nxt = in_ptr;
          state_nxt  = (in_func == FN_FIND) ? S_EVAL : S_EXEC;
        end
      end
      S_EVAL: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          unique case (req_func_r)
            FN_GET: begin
              if (idx_oob) begin
                res_status = ST_BOUNDS;
              end else begin
                res_value      = rd_data;
                res_item_valid = 1'b1;
              end
            end
            FN_FIND: begin
              if (hit) begin
                res_found    = 1'b1;
                res_position = 7'(hit_pos);
              end
            end
            FN_SET: begin
              if (idx_oob) begin
                res_status = ST_BOUNDS;
              end else begin
                cmd.op = CELL_SET;
              end
            end
            FN_INSERT, FN_APPEND: begin
              wr_ptr = ins_pos[IDX_W-1:0];
              if (ins_pos > len_ext) begin
                res_status = ST_BOUNDS;
              end else if (len_ext >= CMP_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                cmd.op  = CELL_INS;
                len_nxt = len_r + LEN_W'(1);
              end
            end
            FN_REMOVE: begin
              if (idx_oob) begin
                res_status = ST_BOUNDS;
              end else begin
                cmd.op  = CELL_REM;
                len_nxt = len_r - LEN_W'(1);
              end
            end
            FN_DROP: begin
              if (len_r != '0) begin
                len_nxt = len_r - LEN_W'(1);
              end
            end
            FN_CLEAR: begin
              len_nxt = '0;
            end
            FN_BURST: begin
              if (idx_oob) begin
                res_status = ST_BOUNDS;
              end else if (burst_cnt != '0) begin
                load_out    = 1'b0;
                state_nxt   = S_BURST;
                burst_n_nxt = 7'(burst_cnt);
                left_nxt    = 7'(burst_cnt);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_BURST: begin
        if (out_free) begin
          load_out       = 1'b1;
          res_value      = rd_data;
          res_item_valid = 1'b1;
          res_position   = burst_n_r;
          res_last       = (left_r == 7'd1);
          rd_ptr_nxt     = rd_ptr_r + IDX_W'(1);
          left_nxt       = left_r - 7'd1;
          if (left_r == 7'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and burst bookkeeping registers.
  always_ff @(posedge clk) begin
    rd_ptr_r  <= rd_ptr_nxt;
    burst_n_r <= burst_n_nxt;
    left_r    <= left_nxt;
    if (in_take) begin
      req_func_r  <= in_func;
      req_index_r <= in_index;
      req_value_r <= in_value_in;
      req_limit_r <= in_count_limit;
    end
  end

  // Output register for one result item.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r     <= res_status;
      out_value_r      <= res_value;
      out_position_r   <= res_position;
      out_found_r      <= res_found;
      out_length_r     <= 7'(len_nxt);
      out_item_valid_r <= res_item_valid;
      out_last_r       <= res_last;
    end
  end

  ile_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .LEN_W (LEN_W)
  ) u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .wr_ptr  (wr_ptr),
    .key     (req_value_r),
    .len     (len_r),
    .rd_ptr  (rd_ptr_r),
    .rd_data (rd_data),
    .hit     (hit),
    .hit_pos (hit_pos)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_position   = out_position_r;
  assign out_found      = out_found_r;
  assign out_length_now = out_length_r;
  assign out_item_valid = out_item_valid_r;
  assign out_last       = out_last_r;

endmodule
